### sv/fcda_pkg.sv
// Package for the fused conjugate dot product and complex axpy unit.
// Holds the Q1.15 sample type, the fixed field widths, the register
// indexes and the round-and-saturate helper. Depends on nothing.
package fcda_pkg;

	// Fixed widths of the stream fields.
	localparam int unsigned SAMPLE_W = 16;
	localparam int unsigned DOT_W    = 48;
	// A sum or difference of two 16x16 products needs 33 bits.
	localparam int unsigned TERM_W   = 2 * SAMPLE_W + 1;
	// w scaled to Q2.30 plus a 33-bit product and the rounding constant.
	localparam int unsigned WSUM_W   = TERM_W + 1;
	localparam int unsigned FRAC_W   = SAMPLE_W - 1;

	localparam int unsigned S_TDATA_W = 6 * SAMPLE_W;
	localparam int unsigned M_TDATA_W = 2 * SAMPLE_W + 2 * DOT_W;

	// Configuration port geometry.
	localparam int unsigned PADDR_W = 3;
	localparam int unsigned PDATA_W = 32;

	// Register indexes, taken from paddr[2].
	localparam logic REG_SCALE_RE = 1'b0;
	localparam logic REG_SCALE_IM = 1'b1;

	typedef logic signed [SAMPLE_W-1:0] q15_t;
	typedef logic signed [TERM_W-1:0]   term_t;

	// Adds w (Q1.15) to a Q2.30 product, rounds half up and saturates the
	// result back to Q1.15.
	function automatic q15_t q15_round_sat(input q15_t w, input term_t prod);
		logic signed [WSUM_W-1:0] sum;
		logic [3:0]               top;
		q15_t                     res;
		sum = {{3{w[SAMPLE_W-1]}}, w, {FRAC_W{1'b0}}}
			+ WSUM_W'(prod)
			+ WSUM_W'(signed'({1'b0, 1'b1, {(FRAC_W-1){1'b0}}}));
		top = sum[WSUM_W-1 -: 4];
		if (top == 4'b0000 || top == 4'b1111) begin
			res = sum[FRAC_W +: SAMPLE_W];
		end else if (top[3]) begin
			res = {1'b1, {(SAMPLE_W-1){1'b0}}};
		end else begin
			res = {1'b0, {(SAMPLE_W-1){1'b1}}};
		end
		return res;
	endfunction

endpackage

### sv/fused_conj_dot_and_axpy_unit.sv
// Top level of the fused conjugate dot product and complex axpy unit.
// Stream in, stream out, APB-style register port; uses fcda_pkg.
//
//   Channel   Dir  Handshake                  Payload
//   s_axis    in   s_axis_tvalid/tready       tdata: a, x, w; tlast: last element
//   m_axis    out  m_axis_tvalid/tready       tdata: w_new, dot; tuser: dot_valid
//   apb       in   psel/penable/pwrite/pready scale_re at 0x0, scale_im at 0x4
//
// One beat is accepted every cycle while the output side keeps up. A beat
// taken sits in the input register until the result register is empty or
// being taken, then moves into the result register and is presented on m_axis.
// All arithmetic (the four 16x16 products per complex multiply, one add and
// one saturating accumulate) sits between those two registers.
// Reset clears the valid bits, the accumulators and the scale registers.
// When m_axis_tready is low and the result register is full, it holds; the
// input register still takes one more beat if empty, after which s_axis_tready drops.
module fused_conj_dot_and_axpy_unit
	import fcda_pkg::*;
#(
	parameter int unsigned ACC_WIDTH = 48
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// Input stream
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	// tdata from bit 0 up: a_re, a_im, x_re, x_im, w_re, w_im (16 bits each)
	input  logic [S_TDATA_W-1:0] s_axis_tdata,
	input  logic                 s_axis_tlast,
	// Output stream
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	// tdata from bit 0 up: w_new_re (16), w_new_im (16), dot_re (48), dot_im (48)
	output logic [M_TDATA_W-1:0] m_axis_tdata,
	// tuser: dot_valid
	output logic                 m_axis_tuser,
	// Register port
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [PADDR_W-1:0]   paddr,
	input  logic [PDATA_W-1:0]   pwdata,
	output logic [PDATA_W-1:0]   prdata,
	output logic                 pready
);

	// Width used to bring the accumulator to the 48-bit output field.
	localparam int unsigned XW = (ACC_WIDTH > DOT_W) ? ACC_WIDTH : DOT_W;

	// Configuration registers.
	q15_t scale_re_q, scale_im_q;

	// Stage 1: input register.
	logic valid_s1;
	q15_t a_re_s1, a_im_s1, x_re_s1, x_im_s1, w_re_s1, w_im_s1;
	logic last_s1;

	// Stage 2: result register.
	logic                     valid_s2;
	q15_t                     w_new_re_s2, w_new_im_s2;
	logic signed [DOT_W-1:0]  dot_re_s2, dot_im_s2;
	logic                     dot_valid_s2;

	// Running sums of conj(a)*x.
	logic signed [ACC_WIDTH-1:0] acc_re_q, acc_im_q;

	// Datapath.
	logic signed [2*SAMPLE_W-1:0] p_rr, p_ii, p_ri, p_ir;
	logic signed [2*SAMPLE_W-1:0] k_rr, k_ii, k_ri, k_ir;
	term_t                        term_re, term_im, kap_re, kap_im;
	logic signed [ACC_WIDTH:0]    acc_re_sum, acc_im_sum;
	logic signed [ACC_WIDTH-1:0]  acc_re_nxt, acc_im_nxt;
	q15_t                         w_new_re, w_new_im;

	logic advance;
	logic cfg_wr;

	// Clamps an accumulator-width value to the 48-bit dot field; for
	// accumulators of 48 bits or less this is a plain sign extension.
	function automatic logic signed [DOT_W-1:0] sat_dot(
		input logic signed [ACC_WIDTH-1:0] v
	);
		logic signed [XW-1:0]   ext;
		logic [XW-DOT_W:0]      upper;
		logic signed [DOT_W-1:0] res;
		ext   = XW'(v);
		upper = ext[XW-1:DOT_W-1];
		if ((&upper) || !(|upper)) begin
			res = ext[DOT_W-1:0];
		end else if (ext[XW-1]) begin
			res = {1'b1, {(DOT_W-1){1'b0}}};
		end else begin
			res = {1'b0, {(DOT_W-1){1'b1}}};
		end
		return res;
	endfunction

	// Clamps a sum one bit wider than an accumulator to the accumulator range.
	function automatic logic signed [ACC_WIDTH-1:0] sat_acc(
		input logic signed [ACC_WIDTH:0] sum
	);
		logic signed [ACC_WIDTH-1:0] res;
		if (sum[ACC_WIDTH] != sum[ACC_WIDTH-1]) begin
			res = sum[ACC_WIDTH] ? {1'b1, {(ACC_WIDTH-1){1'b0}}}
				: {1'b0, {(ACC_WIDTH-1){1'b1}}};
		end else begin
			res = sum[ACC_WIDTH-1:0];
		end
		return res;
	endfunction

	// Flow control: the result register moves when it is empty or taken;
	// the input register moves when it is empty or drains into the result.
	assign advance       = !valid_s2 || m_axis_tready;
	assign s_axis_tready = !valid_s1 || advance;

	// Register port: a write lands at the access phase; pready is tied high.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_comb begin
		case (paddr[2])
			REG_SCALE_RE: prdata = PDATA_W'(scale_re_q);
			REG_SCALE_IM: prdata = PDATA_W'(scale_im_q);
			default:      prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_re_q <= '0;
			scale_im_q <= '0;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_SCALE_RE: scale_re_q <= pwdata[SAMPLE_W-1:0];
				REG_SCALE_IM: scale_im_q <= pwdata[SAMPLE_W-1:0];
				default:      ;
			endcase
		end
	end

	// conj(a)*x: re = ar*xr + ai*xi, im = ar*xi - ai*xr, exact in Q2.30.
	assign p_rr    = a_re_s1 * x_re_s1;
	assign p_ii    = a_im_s1 * x_im_s1;
	assign p_ri    = a_re_s1 * x_im_s1;
	assign p_ir    = a_im_s1 * x_re_s1;
	assign term_re = TERM_W'(p_rr) + TERM_W'(p_ii);
	assign term_im = TERM_W'(p_ri) - TERM_W'(p_ir);

	assign acc_re_sum = (ACC_WIDTH+1)'(acc_re_q) + (ACC_WIDTH+1)'(term_re);
	assign acc_im_sum = (ACC_WIDTH+1)'(acc_im_q) + (ACC_WIDTH+1)'(term_im);
	assign acc_re_nxt = sat_acc(acc_re_sum);
	assign acc_im_nxt = sat_acc(acc_im_sum);

	// kappa*a: re = kr*ar - ki*ai, im = kr*ai + ki*ar, then w + kappa*a.
	assign k_rr   = scale_re_q * a_re_s1;
	assign k_ii   = scale_im_q * a_im_s1;
	assign k_ri   = scale_re_q * a_im_s1;
	assign k_ir   = scale_im_q * a_re_s1;
	assign kap_re = TERM_W'(k_rr) - TERM_W'(k_ii);
	assign kap_im = TERM_W'(k_ri) + TERM_W'(k_ir);

	assign w_new_re = q15_round_sat(w_re_s1, kap_re);
	assign w_new_im = q15_round_sat(w_im_s1, kap_im);

	// Control state of the two stages and the accumulators.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			acc_re_q <= '0;
			acc_im_q <= '0;
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
			end
			// The last element closes the vector: report, then start over.
			if (advance && valid_s1) begin
				acc_re_q <= last_s1 ? '0 : acc_re_nxt;
				acc_im_q <= last_s1 ? '0 : acc_im_nxt;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			a_re_s1 <= s_axis_tdata[0*SAMPLE_W +: SAMPLE_W];
			a_im_s1 <= s_axis_tdata[1*SAMPLE_W +: SAMPLE_W];
			x_re_s1 <= s_axis_tdata[2*SAMPLE_W +: SAMPLE_W];
			x_im_s1 <= s_axis_tdata[3*SAMPLE_W +: SAMPLE_W];
			w_re_s1 <= s_axis_tdata[4*SAMPLE_W +: SAMPLE_W];
			w_im_s1 <= s_axis_tdata[5*SAMPLE_W +: SAMPLE_W];
			last_s1 <= s_axis_tlast;
		end
		if (advance && valid_s1) begin
			w_new_re_s2  <= w_new_re;
			w_new_im_s2  <= w_new_im;
			dot_re_s2    <= last_s1 ? sat_dot(acc_re_nxt) : '0;
			dot_im_s2    <= last_s1 ? sat_dot(acc_im_nxt) : '0;
			dot_valid_s2 <= last_s1;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {dot_im_s2, dot_re_s2, w_new_im_s2, w_new_re_s2};
	assign m_axis_tuser  = dot_valid_s2;

`ifndef SYNTHESIS
	// Closing a vector must leave both accumulators cleared.
	assert property (@(posedge clk) disable iff (!arst_n)
		(advance && valid_s1 && last_s1) |=> (acc_re_q == '0 && acc_im_q == '0))
		else $error("accumulator not cleared after last element");

	// Results that do not close a vector carry zero dot fields.
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !dot_valid_s2) |-> (dot_re_s2 == '0 && dot_im_s2 == '0))
		else $error("dot fields nonzero on a beat without dot_valid");

	// With both stages full and the output stalled, no new beat may enter.
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && valid_s2 && !m_axis_tready) |-> !s_axis_tready)
		else $error("input accepted while the pipeline is full and stalled");
`endif

endmodule
